// ===== hw/rtl/abrf_pkg.sv =====
// ----------------------------------------------------------------------------
// abrf_pkg
// Types and constants for the alpha blended rectangle fill block.
// ----------------------------------------------------------------------------
package abrf_pkg;

    localparam int DIM_W   = 13;
    localparam int COORD_W = 12;
    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int CFG_W   = COLOR_W;
    localparam int IDX_W   = 3;
    localparam int GEO_W   = 16;
    localparam int PROD_W  = 2 * CHAN_W;

    localparam logic [DIM_W-1:0]  MAX_DIM  = DIM_W'(4096);
    localparam logic [CHAN_W-1:0] CHAN_MAX = CHAN_W'(255);

    typedef enum logic [IDX_W-1:0] {
        REG_RECT_X        = 3'd0,
        REG_RECT_Y        = 3'd1,
        REG_RECT_LENGTH   = 3'd2,
        REG_RECT_HEIGHT   = 3'd3,
        REG_IMAGE_HEIGHT  = 3'd4,
        REG_OUTLINE_COLOR = 3'd5,
        REG_FILL_COLOR    = 3'd6,
        REG_ALPHA         = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        REGION_OUTSIDE = 2'd0,
        REGION_OUTLINE = 2'd1,
        REGION_FILL    = 2'd2
    } region_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_col;
        logic [COORD_W-1:0] pixel_row;
        logic [CHAN_W-1:0]  old_red;
        logic [CHAN_W-1:0]  old_green;
        logic [CHAN_W-1:0]  old_blue;
    } px_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] new_red;
        logic [CHAN_W-1:0] new_green;
        logic [CHAN_W-1:0] new_blue;
        region_t           region;
    } px_out_t;

endpackage

// ===== hw/rtl/alpha_blended_rectangle_fill.sv =====
// ----------------------------------------------------------------------------
// alpha_blended_rectangle_fill
// Classifies each pixel against a vertically flipped rectangle and blends
// outline or interior pixels toward their color with a common alpha.
// ----------------------------------------------------------------------------
//
//  channel   ports                              handshake
//  request   start, busy, pixel (px_in_t)       taken when start and not busy
//  result    done, result (px_out_t)            one cycle strobe, no stall
//  config    cfg_wr_en, cfg_index, cfg_data     written when cfg_wr_en high
//
//  one pixel per clock; busy is never raised
//  from the accepting edge to the done strobe a pixel passes through the
//  input register, region/color stage, product stage, divide and result
//  the 8x8 products and the divide by 255 set the stage split
//  reset clears the valid pipeline and loads the register reset values
//
module alpha_blended_rectangle_fill
    import abrf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  px_in_t           pixel,
    output logic             done,
    output px_out_t          result,
    input  logic             cfg_wr_en,
    input  cfg_index_t       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // configuration registers
    logic signed [DIM_W-1:0] rect_x_reg;
    logic signed [DIM_W-1:0] rect_y_reg;
    logic [DIM_W-1:0]        rect_length_reg;
    logic [DIM_W-1:0]        rect_height_reg;
    logic [DIM_W-1:0]        image_height_reg;
    logic [COLOR_W-1:0]      outline_color_reg;
    logic [COLOR_W-1:0]      fill_color_reg;
    logic [CHAN_W-1:0]       alpha_reg;

    // pipeline
    logic                        s1_valid_reg;
    px_in_t                      s1_pix_reg;
    logic                        s2_valid_reg;
    region_t                     s2_region_reg;
    logic [2:0][CHAN_W-1:0]      s2_color_reg;
    logic [2:0][CHAN_W-1:0]      s2_old_reg;
    logic [CHAN_W-1:0]           s2_alpha_reg;
    logic                        s3_valid_reg;
    region_t                     s3_region_reg;
    logic [2:0][PROD_W-1:0]      s3_old_prod_reg;
    logic [2:0][PROD_W-1:0]      s3_color_prod_reg;
    logic                        done_reg;
    px_out_t                     result_reg;

    region_t                     s2_region_next;
    logic [2:0][CHAN_W-1:0]      s2_color_next;
    logic [2:0][PROD_W-1:0]      s3_old_prod_next;
    logic [2:0][PROD_W-1:0]      s3_color_prod_next;
    logic [2:0][CHAN_W-1:0]      blend_next;

    logic [DIM_W-1:0]        len_sat;
    logic [DIM_W-1:0]        hgt_sat;
    logic signed [GEO_W-1:0] col_s;
    logic signed [GEO_W-1:0] row_s;
    logic signed [GEO_W-1:0] left_s;
    logic signed [GEO_W-1:0] right_s;
    logic signed [GEO_W-1:0] top_s;
    logic signed [GEO_W-1:0] bottom_s;
    logic signed [GEO_W-1:0] len_s;
    logic signed [GEO_W-1:0] hgt_s;
    logic signed [GEO_W-1:0] ih_s;
    logic signed [GEO_W-1:0] y_s;
    logic                    in_rect;
    logic                    on_edge;
    logic [CHAN_W-1:0]       alpha_eff;
    logic [CHAN_W-1:0]       alpha_inv;
    logic [PROD_W-1:0]       sum;
    logic [PROD_W-1:0]       quot;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_x_reg        <= '0;
            rect_y_reg        <= '0;
            rect_length_reg   <= '0;
            rect_height_reg   <= '0;
            image_height_reg  <= DIM_W'(1);
            outline_color_reg <= '0;
            fill_color_reg    <= '0;
            alpha_reg         <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_RECT_X:        rect_x_reg        <= cfg_data[DIM_W-1:0];
                REG_RECT_Y:        rect_y_reg        <= cfg_data[DIM_W-1:0];
                REG_RECT_LENGTH:   rect_length_reg   <= cfg_data[DIM_W-1:0];
                REG_RECT_HEIGHT:   rect_height_reg   <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[DIM_W-1:0];
                REG_OUTLINE_COLOR: outline_color_reg <= cfg_data[COLOR_W-1:0];
                REG_FILL_COLOR:    fill_color_reg    <= cfg_data[COLOR_W-1:0];
                REG_ALPHA:         alpha_reg         <= cfg_data[CHAN_W-1:0];
                default:           alpha_reg         <= alpha_reg;
            endcase
        end
    end

    // region and color select
    always_comb
    begin
        len_sat  = (rect_length_reg > MAX_DIM) ? MAX_DIM : rect_length_reg;
        hgt_sat  = (rect_height_reg > MAX_DIM) ? MAX_DIM : rect_height_reg;
        len_s    = {{(GEO_W-DIM_W){1'b0}}, len_sat};
        hgt_s    = {{(GEO_W-DIM_W){1'b0}}, hgt_sat};
        ih_s     = {{(GEO_W-DIM_W){1'b0}}, image_height_reg};
        y_s      = {{(GEO_W-DIM_W){rect_y_reg[DIM_W-1]}}, rect_y_reg};
        left_s   = {{(GEO_W-DIM_W){rect_x_reg[DIM_W-1]}}, rect_x_reg};
        col_s    = {{(GEO_W-COORD_W){1'b0}}, s1_pix_reg.pixel_col};
        row_s    = {{(GEO_W-COORD_W){1'b0}}, s1_pix_reg.pixel_row};
        right_s  = left_s + len_s - GEO_W'(1);
        top_s    = ih_s - y_s - hgt_s;
        bottom_s = ih_s - y_s - GEO_W'(1);
        in_rect  = (len_sat != '0) && (hgt_sat != '0) &&
                   (col_s >= left_s) && (col_s <= right_s) &&
                   (row_s >= top_s) && (row_s <= bottom_s);
        on_edge  = (col_s == left_s) || (col_s == right_s) ||
                   (row_s == top_s) || (row_s == bottom_s);
        if (!in_rect)
        begin
            s2_region_next = REGION_OUTSIDE;
            s2_color_next  = '0;
        end
        else if (on_edge)
        begin
            s2_region_next = REGION_OUTLINE;
            s2_color_next  = outline_color_reg;
        end
        else
        begin
            s2_region_next = REGION_FILL;
            s2_color_next  = fill_color_reg;
        end
    end

    // products; zero alpha leaves an outside pixel unchanged
    always_comb
    begin
        alpha_eff = (s2_region_reg == REGION_OUTSIDE) ? '0 : s2_alpha_reg;
        alpha_inv = CHAN_MAX - alpha_eff;
        for (int i = 0; i < 3; i++)
        begin
            s3_old_prod_next[i]   = s2_old_reg[i] * alpha_inv;
            s3_color_prod_next[i] = s2_color_reg[i] * alpha_eff;
        end
    end

    // sum and exact divide by 255 for every sum up to 255 * 255
    always_comb
    begin
        sum  = '0;
        quot = '0;
        for (int i = 0; i < 3; i++)
        begin
            sum           = s3_old_prod_reg[i] + s3_color_prod_reg[i];
            quot          = PROD_W'((17'(sum) + 17'd1 + 17'(sum[PROD_W-1:CHAN_W])) >> CHAN_W);
            blend_next[i] = quot[CHAN_W-1:0];
        end
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_pix_reg <= pixel;
        end
        if (s1_valid_reg)
        begin
            s2_region_reg <= s2_region_next;
            s2_color_reg  <= s2_color_next;
            s2_old_reg    <= {s1_pix_reg.old_red, s1_pix_reg.old_green,
                              s1_pix_reg.old_blue};
            s2_alpha_reg  <= alpha_reg;
        end
        if (s2_valid_reg)
        begin
            s3_region_reg     <= s2_region_reg;
            s3_old_prod_reg   <= s3_old_prod_next;
            s3_color_prod_reg <= s3_color_prod_next;
        end
        if (s3_valid_reg)
        begin
            result_reg.new_red   <= blend_next[2];
            result_reg.new_green <= blend_next[1];
            result_reg.new_blue  <= blend_next[0];
            result_reg.region    <= s3_region_reg;
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Pixel-by-pixel check of the alpha blended rectangle fill block. A short
// table of pixels around known rectangles comes first, then register settings
// drawn at random, each followed by a burst of pixels at, near and inside the
// rectangle edges, some anywhere. Each result is checked field by field against
// the table entry or the blend the bench works out from its copy of the registers.
// ----------------------------------------------------------------------------
module tb
    import abrf_pkg::*;
();

    localparam int PIPE_DEPTH  = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_GOAL = 900;
    localparam int PLAN_LEN    = 25;

    typedef struct {
        int      setup;
        px_in_t  px;
        bit      typed;
        px_out_t want;
    } fill_case_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    px_in_t           pixel = '0;
    logic             done;
    px_out_t          result;
    logic             cfg_wr_en = 1'b0;
    cfg_index_t       cfg_index = REG_RECT_X;
    logic [CFG_W-1:0] cfg_data = '0;

    // bench copy of the register file
    logic signed [DIM_W-1:0] rect_x_q = '0;
    logic signed [DIM_W-1:0] rect_y_q = '0;
    logic [DIM_W-1:0]        length_q = '0;
    logic [DIM_W-1:0]        height_q = '0;
    logic [DIM_W-1:0]        image_h_q = DIM_W'(1);
    logic [COLOR_W-1:0]      outline_q = '0;
    logic [COLOR_W-1:0]      fill_q = '0;
    logic [CHAN_W-1:0]       alpha_q = '0;

    px_out_t blended_queue [$];
    int      err_count = 0;
    int      cycle_count = 0;
    int      pixels_sent = 0;
    int      settings_used = 0;
    int      gap_pct = 0;
    int      region_seen [3] = '{0, 0, 0};
    int      gap_mix [4] = '{0, 59, 0, 24};

    fill_case_t directed_pixels [PLAN_LEN] = '{
        // reset values: empty rectangle, everything passes
        '{0, {12'd0, 12'd0, 8'h00, 8'h00, 8'h00}, 1'b1, {8'h00, 8'h00, 8'h00, REGION_OUTSIDE}},
        '{0, {12'hfff, 12'hfff, 8'hff, 8'hff, 8'hff}, 1'b1,
          {8'hff, 8'hff, 8'hff, REGION_OUTSIDE}},
        // opaque 4x3 rectangle, columns 10..13, rows 12..14
        '{1, {12'd10, 12'd12, 8'h5a, 8'h5a, 8'h5a}, 1'b1, {8'h11, 8'h22, 8'h33, REGION_OUTLINE}},
        '{1, {12'd11, 12'd13, 8'h5a, 8'h5a, 8'h5a}, 1'b1, {8'haa, 8'hbb, 8'hcc, REGION_FILL}},
        '{1, {12'd12, 12'd13, 8'h00, 8'hff, 8'h00}, 1'b1, {8'haa, 8'hbb, 8'hcc, REGION_FILL}},
        '{1, {12'd13, 12'd14, 8'hff, 8'h00, 8'hff}, 1'b1, {8'h11, 8'h22, 8'h33, REGION_OUTLINE}},
        '{1, {12'd10, 12'd14, 8'h01, 8'h02, 8'h03}, 1'b1, {8'h11, 8'h22, 8'h33, REGION_OUTLINE}},
        '{1, {12'd13, 12'd12, 8'h01, 8'h02, 8'h03}, 1'b1, {8'h11, 8'h22, 8'h33, REGION_OUTLINE}},
        '{1, {12'd9, 12'd13, 8'h12, 8'h34, 8'h56}, 1'b1, {8'h12, 8'h34, 8'h56, REGION_OUTSIDE}},
        '{1, {12'd14, 12'd13, 8'h12, 8'h34, 8'h56}, 1'b1, {8'h12, 8'h34, 8'h56, REGION_OUTSIDE}},
        '{1, {12'd11, 12'd11, 8'h12, 8'h34, 8'h56}, 1'b1, {8'h12, 8'h34, 8'h56, REGION_OUTSIDE}},
        '{1, {12'd11, 12'd15, 8'h12, 8'h34, 8'h56}, 1'b1, {8'h12, 8'h34, 8'h56, REGION_OUTSIDE}},
        // single pixel rectangle, transparent
        '{2, {12'd0, 12'd0, 8'h80, 8'h80, 8'h80}, 1'b1, {8'h80, 8'h80, 8'h80, REGION_OUTLINE}},
        '{2, {12'd1, 12'd0, 8'h80, 8'h80, 8'h80}, 1'b1, {8'h80, 8'h80, 8'h80, REGION_OUTSIDE}},
        '{2, {12'd0, 12'd1, 8'h80, 8'h80, 8'h80}, 1'b1, {8'h80, 8'h80, 8'h80, REGION_OUTSIDE}},
        // oversized length and height clipped to the full image
        '{3, {12'd0, 12'd0, 8'h12, 8'h34, 8'h56}, 1'b0, '0},
        '{3, {12'hfff, 12'hfff, 8'hff, 8'h00, 8'h7f}, 1'b0, '0},
        '{3, {12'd2048, 12'd2048, 8'h00, 8'hff, 8'h80}, 1'b0, '0},
        '{3, {12'd1, 12'd4094, 8'hc3, 8'h3c, 8'h99}, 1'b0, '0},
        // extreme position registers
        '{4, {12'hfff, 12'd1, 8'h10, 8'h20, 8'h30}, 1'b0, '0},
        '{4, {12'hfff, 12'd2000, 8'hf0, 8'he0, 8'hd0}, 1'b0, '0},
        '{4, {12'hffe, 12'd2000, 8'h55, 8'haa, 8'h55}, 1'b0, '0},
        // rows past the image height
        '{5, {12'd105, 12'd60, 8'h40, 8'h80, 8'hc0}, 1'b0, '0},
        '{5, {12'd100, 12'd60, 8'h40, 8'h80, 8'hc0}, 1'b0, '0},
        '{5, {12'd105, 12'd51, 8'h40, 8'h80, 8'hc0}, 1'b0, '0}
    };

    alpha_blended_rectangle_fill dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void rect_bounds(output int left, output int right,
                                        output int top, output int bottom);
        int len;
        int hgt;
        int ry;
        len = (length_q > MAX_DIM) ? int'(MAX_DIM) : int'(length_q);
        hgt = (height_q > MAX_DIM) ? int'(MAX_DIM) : int'(height_q);
        ry = rect_y_q;
        left = rect_x_q;
        right = left + len - 1;
        top = int'(image_h_q) - ry - hgt;
        bottom = top + hgt - 1;
    endfunction

    function automatic logic [CHAN_W-1:0] mix_channel(logic [CHAN_W-1:0] old,
                                                      logic [CHAN_W-1:0] paint);
        int unsigned a;
        int unsigned sum;
        a = alpha_q;
        sum = old * (int'(CHAN_MAX) - a) + paint * a;
        return CHAN_W'(sum / int'(CHAN_MAX));
    endfunction

    function automatic px_out_t blend_pixel(px_in_t px);
        int left, right, top, bottom, col, row;
        logic [COLOR_W-1:0] paint;
        px_out_t res;
        rect_bounds(left, right, top, bottom);
        col = px.pixel_col;
        row = px.pixel_row;
        res.new_red = px.old_red;
        res.new_green = px.old_green;
        res.new_blue = px.old_blue;
        res.region = REGION_OUTSIDE;
        if (col >= left && col <= right && row >= top && row <= bottom)
        begin
            if (col == left || col == right || row == top || row == bottom)
            begin
                res.region = REGION_OUTLINE;
                paint = outline_q;
            end
            else
            begin
                res.region = REGION_FILL;
                paint = fill_q;
            end
            res.new_red = mix_channel(px.old_red, paint[23:16]);
            res.new_green = mix_channel(px.old_green, paint[15:8]);
            res.new_blue = mix_channel(px.old_blue, paint[7:0]);
        end
        return res;
    endfunction

    task automatic flag_mismatch(string field, int got, int want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        px_out_t want;
        if (rst_n && done)
        begin
            if (blended_queue.size() == 0)
                flag_mismatch("unexpected result", int'(result), 0);
            else
            begin
                want = blended_queue.pop_front();
                if (result.new_red !== want.new_red)
                    flag_mismatch("new_red", int'(result.new_red), int'(want.new_red));
                if (result.new_green !== want.new_green)
                    flag_mismatch("new_green", int'(result.new_green), int'(want.new_green));
                if (result.new_blue !== want.new_blue)
                    flag_mismatch("new_blue", int'(result.new_blue), int'(want.new_blue));
                if (result.region !== want.region)
                    flag_mismatch("region", int'(result.region), int'(want.region));
                if (want.region <= REGION_FILL)
                    region_seen[want.region]++;
            end
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_RECT_X:        rect_x_q = value[DIM_W-1:0];
            REG_RECT_Y:        rect_y_q = value[DIM_W-1:0];
            REG_RECT_LENGTH:   length_q = value[DIM_W-1:0];
            REG_RECT_HEIGHT:   height_q = value[DIM_W-1:0];
            REG_IMAGE_HEIGHT:  image_h_q = value[DIM_W-1:0];
            REG_OUTLINE_COLOR: outline_q = value[COLOR_W-1:0];
            REG_FILL_COLOR:    fill_q = value[COLOR_W-1:0];
            REG_ALPHA:         alpha_q = value[CHAN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(int x, int y, int len, int hgt, int image_h,
                               logic [COLOR_W-1:0] outline, logic [COLOR_W-1:0] fill,
                               logic [CHAN_W-1:0] a);
        write_reg(REG_RECT_X, CFG_W'(x));
        write_reg(REG_RECT_Y, CFG_W'(y));
        write_reg(REG_RECT_LENGTH, CFG_W'(len));
        write_reg(REG_RECT_HEIGHT, CFG_W'(hgt));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(image_h));
        write_reg(REG_OUTLINE_COLOR, outline);
        write_reg(REG_FILL_COLOR, fill);
        write_reg(REG_ALPHA, CFG_W'(a));
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (blended_queue.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic issue_pixel(px_in_t px, px_out_t want);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        blended_queue.push_back(want);
        pixels_sent++;
    endtask

    task automatic apply_setup(int setup);
        case (setup)
            1: load_config(10, 5, 4, 3, 20, 24'h112233, 24'haabbcc, 8'hff);
            2: load_config(0, 0, 1, 1, 1, 24'hffffff, 24'h000000, 8'h00);
            3: load_config(0, 0, 8191, 8191, 4096, 24'h00ff00, 24'hff00ff, 8'h80);
            4: load_config(4095, -4096, 2, 4096, 1, 24'h3c5a96, 24'hc3a569, 8'hc8);
            5: load_config(100, -100, 10, 50, 1, 24'h102030, 24'hf0e0d0, 8'h4d);
            default: ;
        endcase
    endtask

    task automatic random_setup();
        int image_h, len, hgt, hsat, x, y, top, lo, hi;
        logic [CHAN_W-1:0] a;
        case ($urandom_range(9))
            0: a = '0;
            1: a = CHAN_MAX;
            default: a = CHAN_W'($urandom);
        endcase
        if ($urandom_range(9) == 0)
        begin
            // raw register values, upper data bits included
            load_config($urandom, $urandom, $urandom, $urandom, $urandom,
                        COLOR_W'($urandom), COLOR_W'($urandom), a);
        end
        else
        begin
            image_h = $urandom_range(4096, 1);
            len = ($urandom_range(3) == 0) ? $urandom_range(4096, 1) : $urandom_range(40, 1);
            hgt = ($urandom_range(3) == 0) ? $urandom_range(4096, 1) : $urandom_range(40, 1);
            if ($urandom_range(19) == 0)
                len = $urandom_range(8191, 4097);
            if ($urandom_range(19) == 0)
                hgt = $urandom_range(8191, 4097);
            if ($urandom_range(29) == 0)
                len = 0;
            if ($urandom_range(29) == 0)
                hgt = 0;
            hsat = (hgt > 4096) ? 4096 : hgt;
            case ($urandom_range(9))
                0: x = -4096;
                1: x = 4095;
                default: x = int'($urandom_range(4135)) - 40;
            endcase
            lo = image_h - hsat - 4095;
            if (lo < -40)
                lo = -40;
            hi = image_h - hsat + 4096;
            if (hi > 4095)
                hi = 4095;
            top = lo + int'($urandom_range(hi - lo));
            y = image_h - top - hsat;
            load_config(x, y, len, hgt, image_h, COLOR_W'($urandom), COLOR_W'($urandom), a);
        end
    endtask

    function automatic logic [COORD_W-1:0] pick_axis(int first, int last);
        int v;
        case ($urandom_range(7))
            0, 1: return COORD_W'($urandom);
            2: v = first + int'($urandom_range(2)) - 1;
            3: v = last + int'($urandom_range(2)) - 1;
            default:
            begin
                if (last < first)
                    v = first;
                else
                    v = first - 1 + int'($urandom_range(last - first + 2));
            end
        endcase
        if (v < 0 || v > 4095)
            v = $urandom_range(4095);
        return COORD_W'(v);
    endfunction

    initial
    begin
        int current;
        int phase;
        int burst;
        int left, right, top, bottom;
        px_in_t px;
        current = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (directed_pixels[i].setup != current)
            begin
                wait_drained();
                current = directed_pixels[i].setup;
                apply_setup(current);
            end
            issue_pixel(directed_pixels[i].px,
                        directed_pixels[i].typed ? directed_pixels[i].want
                                                 : blend_pixel(directed_pixels[i].px));
        end

        phase = 0;
        while (pixels_sent < PLAN_LEN + RANDOM_GOAL)
        begin
            wait_drained();
            random_setup();
            gap_pct = gap_mix[phase % 4];
            rect_bounds(left, right, top, bottom);
            burst = $urandom_range(60, 20);
            repeat (burst)
            begin
                px.pixel_col = pick_axis(left, right);
                px.pixel_row = pick_axis(top, bottom);
                px.old_red = CHAN_W'($urandom);
                px.old_green = CHAN_W'($urandom);
                px.old_blue = CHAN_W'($urandom);
                issue_pixel(px, blend_pixel(px));
            end
            phase++;
        end

        wait_drained();
        $display("%0d pixels sent under %0d register settings", pixels_sent, settings_used);
        $display("pixels outside %0d, on outline %0d, in fill %0d",
                 region_seen[REGION_OUTSIDE], region_seen[REGION_OUTLINE],
                 region_seen[REGION_FILL]);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/abrf_pkg.sv
hw/rtl/alpha_blended_rectangle_fill.sv
sim/tb.sv
